// File: design/lptd_pkg.sv
`timescale 1ns / 1ps

package lptd_pkg;

   // Characters with a meaning of their own in the stream.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_INT   = 8'h69;
   localparam logic [7:0] CH_END   = 8'h65;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_INT   = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_ERR   = 2'd3
   } token_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_LEN  = 4'b0010,
      MODE_BODY = 4'b0100,
      MODE_INT  = 4'b1000
   } mode_type;

   // One classified input byte as it travels from the front end to the parser.
   typedef struct packed {
      logic [7:0] data;
      logic [3:0] digit;
      logic       is_digit;
      logic       is_colon;
      logic       is_int;
      logic       is_end;
      logic       is_minus;
   } byte_class_type;

endpackage

// File: design/lptd_ifs.sv
`timescale 1ns / 1ps

interface lptd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface lptd_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        token_kind;
   logic [7:0]        data_byte;
   logic signed [31:0] int_value;
   logic              last;

   modport source (output valid, output token_kind, output data_byte, output int_value,
                   output last, input ready);
   modport sink (input valid, input token_kind, input data_byte, input int_value,
                 input last, output ready);
endinterface

// File: design/lptd_front.sv
`timescale 1ns / 1ps

module lptd_front
   import lptd_pkg::*;
(
   lptd_req_if.sink       req_ch,
   output logic           push_valid,
   input  logic           push_ready,
   output byte_class_type push_item
);

   logic [7:0] byte_val;
   logic [3:0] digit_val;

   assign byte_val  = req_ch.in_byte;
   assign digit_val = byte_val[3:0] - CH_ZERO[3:0];

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;

   always_comb begin
      push_item.data     = byte_val;
      push_item.digit    = digit_val;
      push_item.is_digit = byte_val inside {[CH_ZERO:CH_NINE]};
      push_item.is_colon = (byte_val == CH_COLON);
      push_item.is_int   = (byte_val == CH_INT);
      push_item.is_end   = (byte_val == CH_END);
      push_item.is_minus = (byte_val == CH_MINUS);
   end

endmodule

// File: design/lptd_queue.sv
`timescale 1ns / 1ps

module lptd_queue
   import lptd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  byte_class_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output byte_class_type pop_item
);

   byte_class_type entries_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/lptd_back.sv
`timescale 1ns / 1ps

module lptd_back
   import lptd_pkg::*;
#(
   parameter int LEN_BITS = 16,
   parameter int INT_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  byte_class_type pop_item,
   lptd_rsp_if.source     rsp_ch
);

   localparam int LW = LEN_BITS + 4;
   localparam int MW = INT_BITS + 1;
   localparam logic [LW-1:0] LEN_MAX = {4'b0000, {LEN_BITS{1'b1}}};
   localparam logic [MW-1:0] CAP = {2'b01, {(INT_BITS - 1){1'b0}}};
   localparam logic [MW-1:0] CAP_DIV10 = CAP / 10;
   localparam logic [INT_BITS-1:0] PMAX = {1'b0, {(INT_BITS - 1){1'b1}}};

   mode_type              mode_ff, mode_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [LEN_BITS-1:0]   left_ff, left_in;
   logic [INT_BITS-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  seen_ff, seen_in;

   logic                  out_valid_ff, out_valid_in;
   token_kind_type        out_kind_ff, out_kind_in;
   logic [7:0]            out_data_ff, out_data_in;
   logic [31:0]           out_ival_ff, out_ival_in;
   logic                  out_last_ff, out_last_in;

   logic                  do_pop;
   logic                  emit;
   logic                  fin;
   logic [LW-1:0]         len_wide;
   logic [LW-1:0]         len_next;
   logic [MW-1:0]         mag_wide;
   logic [MW-1:0]         mag_next;
   logic [INT_BITS-1:0]   val_sat;
   logic signed [63:0]    val_ext;

   // A new byte is taken whenever the output register is free or drains this cycle.
   assign pop_ready = !out_valid_ff || rsp_ch.ready;
   assign do_pop    = pop_valid && pop_ready;

   // Times ten as two shifted adds.
   assign len_wide = LW'(len_ff);
   assign len_next = (len_wide << 3) + (len_wide << 1) + LW'(pop_item.digit);
   assign mag_wide = MW'(mag_ff);
   assign mag_next = (mag_wide << 3) + (mag_wide << 1) + MW'(pop_item.digit);

   assign fin = (left_ff <= LEN_BITS'(1));

   always_comb begin
      if (neg_ff) begin
         val_sat = ~mag_ff + INT_BITS'(1);
      end else begin
         val_sat = (mag_ff > PMAX) ? PMAX : mag_ff;
      end
      val_ext = 64'(signed'(val_sat));
   end

   always_comb begin
      mode_in     = mode_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      seen_in     = seen_ff;
      emit        = 1'b0;
      out_kind_in = KIND_ERR;
      out_data_in = 8'd0;
      out_ival_in = 32'd0;
      out_last_in = 1'b1;

      if (do_pop) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (pop_item.is_digit) begin
                  len_in  = LEN_BITS'(pop_item.digit);
                  mode_in = MODE_LEN;
               end else if (pop_item.is_int) begin
                  mag_in  = '0;
                  neg_in  = 1'b0;
                  seen_in = 1'b0;
                  mode_in = MODE_INT;
               end else begin
                  emit = 1'b1;
               end
            end
            MODE_LEN: begin
               if (pop_item.is_digit) begin
                  if (len_next > LEN_MAX) begin
                     emit = 1'b1;
                  end else begin
                     len_in = len_next[LEN_BITS-1:0];
                  end
               end else if (pop_item.is_colon) begin
                  if (len_ff == '0) begin
                     emit        = 1'b1;
                     out_kind_in = KIND_EMPTY;
                     mode_in     = MODE_IDLE;
                  end else begin
                     left_in = len_ff;
                     len_in  = '0;
                     mode_in = MODE_BODY;
                  end
               end else begin
                  emit = 1'b1;
               end
            end
            MODE_BODY: begin
               emit        = 1'b1;
               out_kind_in = KIND_BODY;
               out_data_in = pop_item.data;
               out_last_in = fin;
               left_in     = fin ? '0 : left_ff - LEN_BITS'(1);
               if (fin) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (pop_item.is_minus && !seen_ff && !neg_ff) begin
                  neg_in = 1'b1;
               end else if (pop_item.is_digit) begin
                  if (mag_wide > CAP_DIV10 || mag_next > CAP) begin
                     mag_in = CAP[INT_BITS-1:0];
                  end else begin
                     mag_in = mag_next[INT_BITS-1:0];
                  end
                  seen_in = 1'b1;
               end else if (pop_item.is_end && seen_ff) begin
                  emit        = 1'b1;
                  out_kind_in = KIND_INT;
                  out_ival_in = val_ext[31:0];
                  mode_in     = MODE_IDLE;
                  mag_in      = '0;
                  neg_in      = 1'b0;
                  seen_in     = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         // Every error token drops the partial token and clears the parser.
         if (emit && out_kind_in == KIND_ERR) begin
            mode_in = MODE_IDLE;
            len_in  = '0;
            left_in = '0;
            mag_in  = '0;
            neg_in  = 1'b0;
            seen_in = 1'b0;
         end
      end

      if (do_pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         len_ff       <= '0;
         left_ff      <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop && emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_ival_ff <= out_ival_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.token_kind = out_kind_ff;
   assign rsp_ch.data_byte  = out_data_ff;
   assign rsp_ch.int_value  = signed'(out_ival_ff);
   assign rsp_ch.last       = out_last_ff;

endmodule

// File: design/length_prefixed_token_decoder.sv
// Decoder for length-prefixed strings ("5:hello") and integers ("i-42e").
// req_ch carries one raw stream byte per transaction. rsp_ch carries zero or
// one token per byte: each string body byte (last set on the final one), an
// empty-string token, a signed integer saturated at INT_BITS, or an error
// token for an unexpected byte or a length above 2^LEN_BITS - 1. After an
// error the decoder is back at idle and the offending byte is consumed.
// Throughput is one byte per cycle in both directions while rsp_ch is
// ready. A byte's token reaches rsp_ch by way of the two-entry queue of
// classified bytes and then the parser's output register.
// When rsp_ch stalls, the output register holds its token and the parser
// stops; the queue absorbs up to two more bytes before req_ch.ready drops.
// Reset (synchronous) empties the queue and the output register and puts
// the parser at idle; bytes are accepted in the first cycle after it.
`timescale 1ns / 1ps

module length_prefixed_token_decoder
   import lptd_pkg::*;
#(
   parameter int LEN_BITS = 16,
   parameter int INT_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   lptd_req_if.sink   req_ch,
   lptd_rsp_if.source rsp_ch
);

   logic           push_valid;
   logic           push_ready;
   byte_class_type push_item;
   logic           pop_valid;
   logic           pop_ready;
   byte_class_type pop_item;

   lptd_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   lptd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   lptd_back #(
      .LEN_BITS (LEN_BITS),
      .INT_BITS (INT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_ch    (rsp_ch)
   );

endmodule
